// File: rtl/core/bounded_window_max_subarray_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded window max subarray block
// Concurrent checks on clk, with or without a disable on rst; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_WINDOW_MAX_SUBARRAY_MACROS_SVH
`define BOUNDED_WINDOW_MAX_SUBARRAY_MACROS_SVH

`ifndef SYNTHESIS
`define BWMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BWMS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BWMS_ASSERT(label, prop, msg)
`define BWMS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: rtl/core/bwms_pkg.sv
// ----------------------------------------------------------------------------
// bwms_pkg
// Widths, controller states and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bwms_pkg;

  localparam int MAX_WINDOW = 1024;
  localparam int ADDR_W     = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int SAMPLE_W   = 32;
  localparam int SUM_W      = 48;
  localparam int POS_W      = 32;
  localparam int LEN_W      = 11;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FRONT_RD,
    S_FRONT_CHK,
    S_BACK_RD,
    S_BACK_CHK,
    S_PUSH,
    S_HEAD_RD,
    S_CALC
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_tail;
    logic drop_head;
    logic drop_tail;
    logic push;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic front_expired;
    logic back_dominated;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/bwms_ctrl.sv
// ----------------------------------------------------------------------------
// bwms_ctrl
// Sequencer: front drops, back drops, push, head read and result load.
// ----------------------------------------------------------------------------
module bwms_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  bwms_pkg::sts_t  sts,
  output bwms_pkg::cmd_t  cmd
);

  bwms_pkg::state_t state;
  bwms_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bwms_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      bwms_pkg::S_IDLE: begin
        in_stall = rst;
        if (in_valid && !rst) begin
          cmd.accept = 1'b1;
          state_next = bwms_pkg::S_FRONT_RD;
        end
      end
      bwms_pkg::S_FRONT_RD: begin
        state_next = sts.count_zero ? bwms_pkg::S_PUSH : bwms_pkg::S_FRONT_CHK;
      end
      bwms_pkg::S_FRONT_CHK: begin
        if (sts.front_expired) begin
          cmd.drop_head = 1'b1;
          state_next    = bwms_pkg::S_FRONT_RD;
        end else begin
          state_next = bwms_pkg::S_BACK_RD;
        end
      end
      bwms_pkg::S_BACK_RD: begin
        cmd.rd_tail = 1'b1;
        state_next  = sts.count_zero ? bwms_pkg::S_PUSH : bwms_pkg::S_BACK_CHK;
      end
      bwms_pkg::S_BACK_CHK: begin
        if (sts.back_dominated) begin
          cmd.drop_tail = 1'b1;
          state_next    = bwms_pkg::S_BACK_RD;
        end else begin
          state_next = bwms_pkg::S_PUSH;
        end
      end
      bwms_pkg::S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = bwms_pkg::S_HEAD_RD;
      end
      bwms_pkg::S_HEAD_RD: begin
        state_next = bwms_pkg::S_CALC;
      end
      bwms_pkg::S_CALC: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = bwms_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bwms_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/bwms_dp.sv
// ----------------------------------------------------------------------------
// bwms_dp
// Prefix sum, deque memory with head and count, best tracking, result register.
// ----------------------------------------------------------------------------
`include "bounded_window_max_subarray_macros.svh"

module bwms_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bwms_pkg::cmd_t                       cmd,
  output bwms_pkg::sts_t                       sts,
  input  logic                                 cfg_wr_en,
  input  logic [bwms_pkg::LEN_W-1:0]           cfg_wr_data,
  input  logic signed [bwms_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 last,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic signed [bwms_pkg::SUM_W-1:0]    window_best,
  output logic signed [bwms_pkg::SUM_W-1:0]    running_best,
  output logic                                 is_last
);

  logic [bwms_pkg::LEN_W-1:0]    max_len;
  logic [bwms_pkg::LEN_W-1:0]    len_eff;
  logic [bwms_pkg::SUM_W-1:0]    prefix;
  logic [bwms_pkg::POS_W-1:0]    position;
  logic [bwms_pkg::POS_W-1:0]    idx;
  logic [bwms_pkg::ADDR_W-1:0]   head;
  logic [bwms_pkg::CNT_W-1:0]    count;
  logic [bwms_pkg::SUM_W-1:0]    best;
  logic [bwms_pkg::SAMPLE_W-1:0] sample_r;
  logic                          last_r;

  logic [bwms_pkg::SUM_W-1:0]    sum_mem [bwms_pkg::MAX_WINDOW];
  logic [bwms_pkg::POS_W-1:0]    pos_mem [bwms_pkg::MAX_WINDOW];
  logic [bwms_pkg::SUM_W-1:0]    rd_sum;
  logic [bwms_pkg::POS_W-1:0]    rd_pos;
  logic [bwms_pkg::ADDR_W-1:0]   rd_addr;
  logic [bwms_pkg::ADDR_W-1:0]   wr_addr;

  logic [bwms_pkg::SUM_W-1:0]    sample_ext;
  logic [bwms_pkg::SUM_W-1:0]    cur;
  logic [bwms_pkg::SUM_W-1:0]    wb;
  logic [bwms_pkg::SUM_W-1:0]    best_next;
  logic [bwms_pkg::SUM_W-1:0]    back_diff;

  always_comb begin
    if (max_len == '0) begin
      len_eff = bwms_pkg::LEN_W'(1);
    end else if (max_len > bwms_pkg::LEN_W'(bwms_pkg::MAX_WINDOW)) begin
      len_eff = bwms_pkg::LEN_W'(bwms_pkg::MAX_WINDOW);
    end else begin
      len_eff = max_len;
    end
  end

  assign idx        = position + bwms_pkg::POS_W'(1);
  assign wr_addr    = head + count[bwms_pkg::ADDR_W-1:0];
  assign rd_addr    = cmd.rd_tail ? (wr_addr - bwms_pkg::ADDR_W'(1)) : head;
  assign sample_ext = {{(bwms_pkg::SUM_W-bwms_pkg::SAMPLE_W){sample_r[bwms_pkg::SAMPLE_W-1]}},
                       sample_r};
  assign cur        = prefix + sample_ext;
  assign wb         = cur - rd_sum;
  assign best_next  = ($signed(wb) > $signed(best)) ? wb : best;
  assign back_diff  = rd_sum - prefix;

  assign sts.count_zero     = (count == '0);
  assign sts.front_expired  = ((idx - rd_pos) >= bwms_pkg::POS_W'(len_eff));
  assign sts.back_dominated = !back_diff[bwms_pkg::SUM_W-1];
  assign sts.out_free       = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      sum_mem[wr_addr] <= prefix;
      pos_mem[wr_addr] <= idx;
    end
    rd_sum <= sum_mem[rd_addr];
    rd_pos <= pos_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= sample;
      last_r   <= last;
    end
    if (cmd.load_out) begin
      window_best  <= wb;
      running_best <= best_next;
      is_last      <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len   <= bwms_pkg::LEN_W'(1);
      prefix    <= '0;
      position  <= '0;
      head      <= '0;
      count     <= '0;
      best      <= {1'b1, {(bwms_pkg::SUM_W-1){1'b0}}};
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_len <= cfg_wr_data;
      end
      if (cmd.drop_head) begin
        head  <= head + bwms_pkg::ADDR_W'(1);
        count <= count - bwms_pkg::CNT_W'(1);
      end
      if (cmd.drop_tail) begin
        count <= count - bwms_pkg::CNT_W'(1);
      end
      if (cmd.push) begin
        count <= count + bwms_pkg::CNT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
        if (last_r) begin
          prefix   <= '0;
          position <= '0;
          head     <= '0;
          count    <= '0;
          best     <= {1'b1, {(bwms_pkg::SUM_W-1){1'b0}}};
        end else begin
          prefix   <= cur;
          position <= idx;
          best     <= best_next;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `BWMS_ASSERT(a_pop_nonempty, (cmd.drop_head || cmd.drop_tail) |-> (count != '0), "pop on empty deque")
  `BWMS_ASSERT(a_push_room, cmd.push |-> !count[bwms_pkg::ADDR_W], "push on full deque")
  `BWMS_ASSERT(a_load_free, cmd.load_out |-> (!out_valid || !out_stall), "result overwritten while held")
  `BWMS_ASSERT(a_count_bound, count <= bwms_pkg::CNT_W'(bwms_pkg::MAX_WINDOW), "deque count out of range")

endmodule

// File: rtl/core/bounded_window_max_subarray.sv
// Sequence: accept, front drops, back drops, push, head read, then result load; no new
//   sample is accepted until the result of the one before it is loaded.
// Each step shares the single deque memory read port; a held result delays the load for
//   as long as out_stall stays high.
// Reset: rst, synchronous; clears the sequence state and sets max_len to 1.
// ----------------------------------------------------------------------------
// bounded_window_max_subarray
// Best sum of a run of 1..max_len samples (0 acts as 1, capped at 1024) ending at each sample, and the best so far.
// ----------------------------------------------------------------------------
module bounded_window_max_subarray (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [bwms_pkg::LEN_W-1:0]           cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [bwms_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [bwms_pkg::SUM_W-1:0]    window_best,
  output logic signed [bwms_pkg::SUM_W-1:0]    running_best,
  output logic                                 is_last
);

  bwms_pkg::cmd_t cmd;
  bwms_pkg::sts_t sts;

  bwms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bwms_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .sample       (sample),
    .last         (last),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .window_best  (window_best),
    .running_best (running_best),
    .is_last      (is_last)
  );

endmodule

// File: test/tb_bounded_window_max_subarray.sv
// ----------------------------------------------------------------------------
// Testbench for bounded_window_max_subarray
// Streams signed samples through the valid/stall handshake with random idling
// on both sides. A scoreboard tracks the prefix sum and the monotonic deque of
// earlier prefixes to predict the best bounded-length run sum and the running
// best of each transaction, then checks every result field in order.
// ----------------------------------------------------------------------------
module tb_bounded_window_max_subarray;

  localparam logic signed [bwms_pkg::SAMPLE_W-1:0] SAMPLE_MAX =
    {1'b0, {(bwms_pkg::SAMPLE_W-1){1'b1}}};
  localparam logic signed [bwms_pkg::SAMPLE_W-1:0] SAMPLE_MIN =
    {1'b1, {(bwms_pkg::SAMPLE_W-1){1'b0}}};

  typedef enum int {K_WIDE, K_NARROW, K_EDGE, K_RISING, K_FALLING} sample_mix_t;

  typedef struct packed {
    logic [bwms_pkg::SUM_W-1:0] window_best;
    logic [bwms_pkg::SUM_W-1:0] running_best;
    logic                       is_last;
  } run_sums_t;

  class subarray_tracker;
    logic [bwms_pkg::LEN_W-1:0]  len_reg;
    logic [bwms_pkg::SUM_W-1:0]  prefix;
    logic [bwms_pkg::POS_W-1:0]  pos;
    logic [bwms_pkg::SUM_W-1:0]  dq_sum [bwms_pkg::MAX_WINDOW];
    logic [bwms_pkg::POS_W-1:0]  dq_pos [bwms_pkg::MAX_WINDOW];
    logic [bwms_pkg::ADDR_W-1:0] head;
    logic [bwms_pkg::CNT_W-1:0]  count;
    logic [bwms_pkg::SUM_W-1:0]  best;
    run_sums_t                   expected_sums[$];
    int                          errors;
    int                          checked;
    int                          deepest;

    function new();
      len_reg = bwms_pkg::LEN_W'(1);
      errors  = 0;
      checked = 0;
      deepest = 0;
      clear_seq();
    endfunction

    function void clear_seq();
      prefix = '0;
      pos    = '0;
      head   = '0;
      count  = '0;
      best   = {1'b1, {(bwms_pkg::SUM_W-1){1'b0}}};
    endfunction

    function void note_sample(logic signed [bwms_pkg::SAMPLE_W-1:0] s, logic lst);
      int unsigned                 reach;
      logic [bwms_pkg::POS_W-1:0]  idx;
      logic [bwms_pkg::ADDR_W-1:0] tail;
      logic [bwms_pkg::SUM_W-1:0]  cur;
      logic [bwms_pkg::SUM_W-1:0]  diff;
      logic [bwms_pkg::SUM_W-1:0]  wb;
      bit                          popping;
      run_sums_t                   r;
      reach = len_reg;
      if (reach == 0) reach = 1;
      if (reach > bwms_pkg::MAX_WINDOW) reach = bwms_pkg::MAX_WINDOW;
      idx = pos + 1'b1;
      // drop expired entries at the front
      while (count != 0 && (idx - dq_pos[head]) >= reach) begin
        head  = head + 1'b1;
        count = count - 1'b1;
      end
      // drop entries not smaller than the new prefix at the back
      popping = 1'b1;
      while (count != 0 && popping) begin
        tail = head + count[bwms_pkg::ADDR_W-1:0] - 1'b1;
        diff = dq_sum[tail] - prefix;
        if (diff[bwms_pkg::SUM_W-1]) popping = 1'b0;
        else count = count - 1'b1;
      end
      if (count < bwms_pkg::MAX_WINDOW) begin
        tail = head + count[bwms_pkg::ADDR_W-1:0];
        dq_sum[tail] = prefix;
        dq_pos[tail] = idx;
        count = count + 1'b1;
      end
      if (count > deepest) deepest = count;
      cur = prefix + {{(bwms_pkg::SUM_W-bwms_pkg::SAMPLE_W){s[bwms_pkg::SAMPLE_W-1]}}, s};
      wb  = cur - dq_sum[head];
      if ($signed(wb) > $signed(best)) best = wb;
      r.window_best  = wb;
      r.running_best = best;
      r.is_last      = lst;
      expected_sums.insert(expected_sums.size(), r);
      prefix = cur;
      pos    = idx;
      if (lst) clear_seq();
    endfunction

    function void check_result(logic [bwms_pkg::SUM_W-1:0] wb,
                               logic [bwms_pkg::SUM_W-1:0] rb, logic il);
      run_sums_t e;
      checked++;
      if (expected_sums.size() == 0) begin
        $error("result transaction with no expected result pending");
        errors++;
      end else begin
        e = expected_sums[0];
        expected_sums.delete(0);
        if (wb !== e.window_best) begin
          $error("window_best: expected %0d, got %0d", $signed(e.window_best), $signed(wb));
          errors++;
        end
        if (rb !== e.running_best) begin
          $error("running_best: expected %0d, got %0d", $signed(e.running_best), $signed(rb));
          errors++;
        end
        if (il !== e.is_last) begin
          $error("is_last: expected %0d, got %0d", e.is_last, il);
          errors++;
        end
      end
    endfunction
  endclass

  logic                                 clk;
  logic                                 rst;
  logic                                 cfg_wr_en;
  logic [bwms_pkg::LEN_W-1:0]           cfg_wr_data;
  logic                                 in_valid;
  logic                                 in_stall;
  logic signed [bwms_pkg::SAMPLE_W-1:0] sample;
  logic                                 last;
  logic                                 out_valid;
  logic                                 out_stall;
  logic signed [bwms_pkg::SUM_W-1:0]    window_best;
  logic signed [bwms_pkg::SUM_W-1:0]    running_best;
  logic                                 is_last;

  subarray_tracker tracker;
  bit              quiet;
  int              hold_len;
  int              len_writes;

  bounded_window_max_subarray u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .window_best  (window_best),
    .running_best (running_best),
    .is_last      (is_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [bwms_pkg::SAMPLE_W-1:0] draw_sample(sample_mix_t kind);
    case (kind)
      K_WIDE: begin
        return $urandom;
      end
      K_NARROW: begin
        return $urandom_range(40) - 20;
      end
      K_EDGE: begin
        case ($urandom_range(4))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      K_RISING: begin
        return ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 1000);
      end
      default: begin
        return 0 - $urandom_range(1000);
      end
    endcase
  endfunction

  task automatic send(input logic signed [bwms_pkg::SAMPLE_W-1:0] s, input logic lst);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    last     <= lst;
    do @(posedge clk); while (in_stall);
    tracker.note_sample(s, lst);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.expected_sums.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_len(input logic [bwms_pkg::LEN_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.len_reg = v;
    len_writes++;
  endtask

  initial begin : result_side
    int n;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
      end else begin
        n = quiet ? 0 : $urandom_range(0, 3);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      tracker.check_result(window_best, running_best, is_last);
    end
  end

  initial begin : stimulus
    int                         total;
    int                         seq_mean;
    int                         burst;
    logic [bwms_pkg::LEN_W-1:0] len_pick;
    sample_mix_t                mix;
    tracker    = new();
    quiet      = 1'b0;
    hold_len   = 0;
    len_writes = 0;
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    sample      <= '0;
    last        <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset length of one
    send(SAMPLE_MAX, 1'b0);
    send(SAMPLE_MIN, 1'b0);
    send(0, 1'b0);
    send(-1, 1'b1);
    drain();
    // zero length acts as one
    write_len('0);
    send(5, 1'b0);
    send(-3, 1'b1);
    drain();
    // oversized length clamps to full depth; equal prefixes drop from the back
    write_len('1);
    send(SAMPLE_MAX, 1'b0);
    send(SAMPLE_MAX, 1'b0);
    send(SAMPLE_MIN, 1'b0);
    send(SAMPLE_MIN, 1'b0);
    send(3, 1'b0);
    send(-3, 1'b0);
    send(0, 1'b0);
    send(0, 1'b0);
    send(7, 1'b1);
    drain();
    // shorten the window mid-sequence
    write_len(11'd5);
    send(4, 1'b0);
    send(-9, 1'b0);
    send(6, 1'b0);
    send(2, 1'b0);
    drain();
    write_len(11'd2);
    send(-1, 1'b0);
    send(8, 1'b0);
    send(1, 1'b1);
    drain();
    total = 22;

    // deepen the deque with a long rising run, then end the sequence with SAMPLE_MIN
    write_len(11'd1024);
    repeat (1100) send(draw_sample(K_RISING), 1'b0);
    send(SAMPLE_MIN, 1'b1);
    drain();
    total += 1101;

    hold_len = 150;
    while (total < 1850) begin
      quiet = ($urandom_range(3) == 0);
      case ($urandom_range(9))
        0: len_pick = '0;
        1: len_pick = 11'd1;
        2: len_pick = 11'd2;
        3: len_pick = 11'd3;
        4: len_pick = 11'd1023;
        5: len_pick = 11'd1024;
        6: len_pick = 11'd1025;
        7: len_pick = '1;
        8: len_pick = bwms_pkg::LEN_W'($urandom_range(4, 64));
        default: len_pick = bwms_pkg::LEN_W'($urandom_range(1, 2047));
      endcase
      write_len(len_pick);
      case ($urandom_range(3))
        0: seq_mean = 1;
        1: seq_mean = 4;
        2: seq_mean = 20;
        default: seq_mean = 200;
      endcase
      mix   = sample_mix_t'($urandom_range(4));
      burst = $urandom_range(20, 80);
      repeat (burst) begin
        send(draw_sample(($urandom_range(3) == 0) ? sample_mix_t'($urandom_range(4)) : mix),
             ($urandom_range(seq_mean - 1) == 0));
        total++;
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Checked %0d result transactions over %0d max_len writes; deepest deque %0d.",
             tracker.checked, len_writes, tracker.deepest);
    $display("Run included a long output hold-off and a long rising run that deepens the deque.");
    if (tracker.errors == 0 && tracker.expected_sums.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
